@@ sv/ued_pkg.sv @@
// Shared types, constants and helpers of the backslash-u escape decoder.
`default_nettype none
package ued_pkg;

    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_U        = 8'h75;
    localparam logic [2:0] ESC_NIBBLES = 3'd4;
    localparam int         QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_BSLASH = 2'd1,
        MODE_ESCAPE = 2'd2
    } t_mode;

    // One classified input byte: one or two code units for the back end.
    typedef struct packed {
        logic        two;
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic        last;
    } t_entry;

    // Write request from the front end into the queue.
    typedef struct packed {
        logic   wr;
        t_entry entry;
    } t_qwr;

    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (b inside {[8'h30:8'h39]}) begin
                d = b - 8'h30;
            end else if (b inside {[8'h61:8'h66]}) begin
                d = b - 8'h57;
            end
            hex_nibble = d[3:0];
        end
    endfunction

endpackage
`default_nettype wire

@@ sv/ued_front.sv @@
// Front end: accept bytes, track escape state, classify into code-unit entries.
`default_nettype none
module ued_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire logic [7:0]      i_in_byte,
    input  wire logic            i_in_last,
    output ued_pkg::t_qwr        o_qwr
);

    ued_pkg::t_mode r_mode, n_mode;
    logic [2:0]     r_cnt, n_cnt;
    logic [15:0]    r_val, n_val;

    always_comb begin
        logic [1:0]  n;
        logic [15:0] u0;
        logic [15:0] u1;
        n      = 2'd0;
        u0     = 16'h0000;
        u1     = 16'h0000;
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_val  = r_val;

        case (r_mode)
            ued_pkg::MODE_BSLASH: begin
                if (i_in_byte == ued_pkg::CH_U) begin
                    n_mode = ued_pkg::MODE_ESCAPE;
                    n_cnt  = 3'd0;
                    n_val  = 16'h0000;
                end else begin
                    u0 = {8'h00, ued_pkg::CH_BSLASH};
                    n  = 2'd1;
                    if (i_in_byte == ued_pkg::CH_BSLASH) begin
                        n_mode = ued_pkg::MODE_BSLASH;
                    end else begin
                        u1     = {8'h00, i_in_byte};
                        n      = 2'd2;
                        n_mode = ued_pkg::MODE_IDLE;
                    end
                end
            end
            ued_pkg::MODE_ESCAPE: begin
                if (i_in_byte == ued_pkg::CH_BSLASH) begin
                    u0     = r_val;
                    n      = 2'd1;
                    n_mode = ued_pkg::MODE_BSLASH;
                end else begin
                    n_val = {r_val[11:0], ued_pkg::hex_nibble(i_in_byte)};
                    n_cnt = r_cnt + 3'd1;
                    if (n_cnt >= ued_pkg::ESC_NIBBLES) begin
                        u0     = n_val;
                        n      = 2'd1;
                        n_mode = ued_pkg::MODE_IDLE;
                    end
                end
            end
            default: begin
                if (i_in_byte == ued_pkg::CH_BSLASH) begin
                    n_mode = ued_pkg::MODE_BSLASH;
                end else begin
                    u0     = {8'h00, i_in_byte};
                    n      = 2'd1;
                    n_mode = ued_pkg::MODE_IDLE;
                end
            end
        endcase

        if (i_in_last) begin
            // flush a pending backslash or an open escape
            if (n_mode == ued_pkg::MODE_BSLASH || n_mode == ued_pkg::MODE_ESCAPE) begin
                if (n == 2'd0) begin
                    u0 = (n_mode == ued_pkg::MODE_BSLASH) ?
                         {8'h00, ued_pkg::CH_BSLASH} : n_val;
                end else begin
                    u1 = (n_mode == ued_pkg::MODE_BSLASH) ?
                         {8'h00, ued_pkg::CH_BSLASH} : n_val;
                end
                n = n + 2'd1;
            end
            n_mode = ued_pkg::MODE_IDLE;
            n_cnt  = 3'd0;
            n_val  = 16'h0000;
        end else if (n_mode != ued_pkg::MODE_ESCAPE) begin
            n_cnt = 3'd0;
            n_val = 16'h0000;
        end

        o_qwr.wr          = i_take && (n != 2'd0);
        o_qwr.entry.two   = (n == 2'd2);
        o_qwr.entry.unit0 = u0;
        o_qwr.entry.unit1 = u1;
        o_qwr.entry.last  = i_in_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ued_pkg::MODE_IDLE;
            r_cnt  <= 3'd0;
            r_val  <= 16'h0000;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_val  <= n_val;
        end
    end

endmodule
`default_nettype wire

@@ sv/ued_queue.sv @@
// Short queue of classified entries between the front and back ends.
`default_nettype none
module ued_queue #(
    parameter int QUEUE_DEPTH = ued_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ued_pkg::t_qwr   i_qwr,
    input  wire logic            i_rd,
    output logic                 o_full,
    output logic                 o_nonempty,
    output ued_pkg::t_entry      o_head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);

    ued_pkg::t_entry r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    logic            wr_en, rd_en;

    assign o_full     = (r_cnt == DEPTH_C);
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rp];
    assign wr_en      = i_qwr.wr && !o_full;
    assign rd_en      = i_rd && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_qwr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + PW'(1);
            end
            if (rd_en) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/ued_back.sv @@
// Back end: expand queued entries into single code units in an output register.
`default_nettype none
module ued_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_nonempty,
    input  wire ued_pkg::t_entry i_head,
    output logic                 o_rd,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output logic [15:0]          o_code_unit,
    output logic                 o_out_last
);

    logic        r_valid;
    logic        r_phase;
    logic [15:0] r_unit;
    logic        r_last;
    logic        load;

    assign load        = i_nonempty && (!r_valid || i_pop);
    // release the entry once its final unit is loaded
    assign o_rd        = load && (r_phase || !i_head.two);
    assign o_empty     = !r_valid;
    assign o_code_unit = r_unit;
    assign o_out_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= !r_phase && i_head.two;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_phase) begin
                r_unit <= i_head.unit1;
                r_last <= i_head.last;
            end else begin
                r_unit <= i_head.unit0;
                r_last <= i_head.last && !i_head.two;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/unicode_escape_decoder_top.sv @@
// Top level of the backslash-u escape decoder.
//
// Usage:
//   Input channel is a queue write port: drive i_in_byte/i_in_last and raise
//   push; a transaction completes on a clock edge with push high and full low.
//   Output channel is a queue read port: while empty is low, o_code_unit and
//   o_out_last show the oldest code unit; a transaction completes on a clock
//   edge with pop high and empty low.
//   Each byte yields zero, one or two code units. o_out_last marks the final
//   code unit of a string (the one caused by the byte with i_in_last set).
// Data path and throughput:
//   The front end classifies one byte per cycle while full is low and writes
//   at most one queue entry per byte. The accepting edge writes the queue; the
//   output register is loaded from the queue head once it is empty or popped.
//   The back end loads one code unit per cycle at those times, keeping a two-unit
//   entry until both are loaded; the output register rate is one unit per cycle.
// Stalls and reset:
//   When pop stays low the output register holds, the queue fills, and full
//   rises once all QUEUE_DEPTH entries are taken; push is then ignored.
//   Reset (synchronous, active low) empties the queue and output register
//   and returns the parser to idle with no pending backslash.
`default_nettype none
module unicode_escape_decoder_top #(
    parameter int QUEUE_DEPTH = ued_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      o_code_unit,
    output logic             o_out_last
);

    ued_pkg::t_qwr   qwr;
    ued_pkg::t_entry head;
    logic            q_full;
    logic            q_nonempty;
    logic            q_rd;
    logic            take;

    // accept a byte only while the queue has room
    assign take = push && !q_full;
    assign full = q_full;

    ued_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_qwr     (qwr)
    );

    ued_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qwr      (qwr),
        .i_rd       (q_rd),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (head)
    );

    ued_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nonempty  (q_nonempty),
        .i_head      (head),
        .o_rd        (q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_code_unit (o_code_unit),
        .o_out_last  (o_out_last)
    );

endmodule
`default_nettype wire

@@ tb/unicode_escape_decoder_top_test.sv @@
// Testbench of the backslash-u escape decoder: random and directed byte strings checked against a predictor.
module unicode_escape_decoder_top_test;

    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_A_LOWER = 8'h61;
    localparam logic [7:0] CH_F_LOWER = 8'h66;
    localparam int         STALL_LIMIT = 4000;
    localparam int         HOLD_CYCLES = 400;
    localparam int         MAX_REPORTS = 10;

    // One decoded code unit as it should leave the block.
    typedef struct packed {
        logic [15:0] unit;
        logic        last;
    } t_code_unit;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_in_byte;
    logic        i_in_last;
    logic        empty;
    logic        pop;
    logic [15:0] o_code_unit;
    logic        o_out_last;

    // Decoder state as the predictor tracks it.
    ued_pkg::t_mode dec_mode;
    logic [2:0]     dec_count;
    logic [15:0]    dec_value;

    // Code units predicted but not yet popped, oldest first.
    t_code_unit  pending_units[$];
    t_code_unit  head_unit;

    int mismatch_count;
    int bytes_sent;
    int quiet_cycles;

    // Sender pacing: bursts of back-to-back bytes, random gaps between them.
    bit tx_gaps_on;
    int tx_burst_left;

    // Receiver pacing: runs of popping and stalling, plus a requested hold-off.
    int rx_stall_pct;
    int hold_request;
    int hold_left;
    int rx_run_left;
    bit rx_popping;

    unicode_escape_decoder_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .empty       (empty),
        .pop         (pop),
        .o_code_unit (o_code_unit),
        .o_out_last  (o_out_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Advance the predicted decoder by one byte and queue the code units it yields.
    task automatic predict_units(input logic [7:0] b, input logic last);
        logic [15:0] units [0:1];
        int          n;
        logic [3:0]  nib;
        t_code_unit  cu;
        begin
            n = 0;
            // A pending backslash not followed by 'u' leaves as itself; the byte is
            // then handled from idle and may open a new escape.
            if (dec_mode == ued_pkg::MODE_BSLASH && b != ued_pkg::CH_U) begin
                units[n] = {8'h00, ued_pkg::CH_BSLASH};
                n++;
                dec_mode = ued_pkg::MODE_IDLE;
            end
            case (dec_mode)
                ued_pkg::MODE_BSLASH: begin
                    dec_mode  = ued_pkg::MODE_ESCAPE;
                    dec_count = 3'd0;
                    dec_value = 16'h0000;
                end
                ued_pkg::MODE_ESCAPE: begin
                    if (b == ued_pkg::CH_BSLASH) begin
                        // Close the escape early; the backslash may start another.
                        units[n] = dec_value;
                        n++;
                        dec_mode = ued_pkg::MODE_BSLASH;
                    end else begin
                        // Only lowercase hex adds value; anything else shifts in zero.
                        nib = 4'h0;
                        if (b >= CH_0 && b <= CH_9) begin
                            nib = 4'(b - CH_0);
                        end else if (b >= CH_A_LOWER && b <= CH_F_LOWER) begin
                            nib = 4'(b - CH_A_LOWER + 8'd10);
                        end
                        dec_value = {dec_value[11:0], nib};
                        dec_count = dec_count + 3'd1;
                        if (dec_count >= ued_pkg::ESC_NIBBLES) begin
                            units[n] = dec_value;
                            n++;
                            dec_mode = ued_pkg::MODE_IDLE;
                        end
                    end
                end
                default: begin
                    if (b == ued_pkg::CH_BSLASH) begin
                        dec_mode = ued_pkg::MODE_BSLASH;
                    end else begin
                        units[n] = {8'h00, b};
                        n++;
                        dec_mode = ued_pkg::MODE_IDLE;
                    end
                end
            endcase
            if (last) begin
                // End of string flushes a pending backslash or an open escape.
                if (dec_mode == ued_pkg::MODE_BSLASH) begin
                    units[n] = {8'h00, ued_pkg::CH_BSLASH};
                    n++;
                end else if (dec_mode == ued_pkg::MODE_ESCAPE) begin
                    units[n] = dec_value;
                    n++;
                end
                dec_mode  = ued_pkg::MODE_IDLE;
                dec_count = 3'd0;
                dec_value = 16'h0000;
            end else if (dec_mode != ued_pkg::MODE_ESCAPE) begin
                dec_count = 3'd0;
                dec_value = 16'h0000;
            end
            for (int i = 0; i < n; i++) begin
                cu.unit = units[i];
                cu.last = last && (i == n - 1);
                pending_units.push_back(cu);
            end
        end
    endtask

    // Offer one byte and hold it until the block takes it; insert a gap between bursts when gaps are on.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        begin
            if (tx_burst_left == 0) begin
                tx_burst_left = $urandom_range(1, 24);
                gap = tx_gaps_on ? $urandom_range(1, 12) : 0;
                repeat (gap) begin
                    @(negedge i_clk);
                    push <= 1'b0;
                    @(posedge i_clk);
                end
            end
            tx_burst_left--;
            @(negedge i_clk);
            push      <= 1'b1;
            i_in_byte <= b;
            i_in_last <= last;
            @(posedge i_clk);
            while (full) @(posedge i_clk);
            predict_units(b, last);
            bytes_sent++;
        end
    endtask

    // Drop push once a stretch of stimulus is over so nothing stale gets taken.
    task automatic stop_sending();
        begin
            @(negedge i_clk);
            push <= 1'b0;
        end
    endtask

    task automatic send_text(input string s, input bit last_at_end);
        begin
            for (int i = 0; i < s.len(); i++) begin
                send_byte(s[i], last_at_end && (i == s.len() - 1));
            end
        end
    endtask

    function automatic logic [7:0] hex_char(input int v);
        begin
            hex_char = (v < 10) ? 8'(CH_0 + v) : 8'(CH_A_LOWER + v - 10);
        end
    endfunction

    // Plain bytes at the value extremes, the end digits of both hex ranges, uppercase and non-hex
    // nibbles, early close by backslash and by end of string, lone backslashes.
    task automatic test_directed();
        begin
            send_byte(8'h01, 1'b0);
            send_byte(8'hFF, 1'b1);
            send_text("\\u09af", 1'b0);
            send_text("\\uFg7A", 1'b0);
            send_text("\\x", 1'b0);
            send_text("\\u12\\u", 1'b1);
            send_text("\\", 1'b1);
            send_text("\\u3", 1'b1);
            stop_sending();
        end
    endtask

    // Strings with random content: escapes of 0..4 digits, some with a random byte for a digit,
    // mixed with plain text, high bytes, backslash-led pairs and random bytes.
    task automatic test_escape_strings(input int n_bytes);
        logic [7:0] text[$];
        int         stop_at;
        int         pieces;
        int         digits;
        begin
            stop_at = bytes_sent + n_bytes;
            while (bytes_sent < stop_at) begin
                text.delete();
                pieces = $urandom_range(1, 5);
                repeat (pieces) begin
                    case ($urandom_range(0, 5))
                        0, 1: begin
                            text.push_back(ued_pkg::CH_BSLASH);
                            text.push_back(ued_pkg::CH_U);
                            digits = $urandom_range(0, 4);
                            repeat (digits) begin
                                if ($urandom_range(0, 7) == 0) begin
                                    text.push_back(8'($urandom_range(1, 255)));
                                end else begin
                                    text.push_back(hex_char($urandom_range(0, 15)));
                                end
                            end
                        end
                        2: text.push_back(8'($urandom_range(8'h20, 8'h7E)));
                        3: text.push_back(8'($urandom_range(8'h80, 8'hFF)));
                        4: begin
                            text.push_back(ued_pkg::CH_BSLASH);
                            text.push_back(8'($urandom_range(1, 255)));
                        end
                        default: text.push_back(8'($urandom_range(1, 255)));
                    endcase
                end
                foreach (text[i]) begin
                    send_byte(text[i], i == text.size() - 1);
                end
            end
            stop_sending();
        end
    endtask

    // Strings at full rate on both sides: no sender gaps, no receiver stalls.
    task automatic test_full_rate();
        begin
            tx_gaps_on   = 1'b0;
            rx_stall_pct = 0;
            test_escape_strings(200);
            tx_gaps_on   = 1'b1;
            rx_stall_pct = 35;
        end
    endtask

    // Hold the receiver off long enough that the block fills and raises full
    // while the sender keeps offering bytes.
    task automatic test_hold_off();
        begin
            tx_gaps_on   = 1'b0;
            hold_request = HOLD_CYCLES;
            test_escape_strings(60);
            tx_gaps_on   = 1'b1;
        end
    endtask

    // Unstructured bytes with string ends at random points.
    task automatic test_noise();
        begin
            repeat (400) begin
                send_byte(8'($urandom_range(1, 255)), $urandom_range(0, 9) == 0);
            end
            stop_sending();
        end
    endtask

    // Receiver: pop on a run pattern of its own; a hold-off request overrides it.
    initial begin
        pop         = 1'b0;
        hold_left   = 0;
        rx_run_left = 0;
        rx_popping  = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (rx_stall_pct == 0) begin
                pop <= 1'b1;
            end else begin
                if (rx_run_left == 0) begin
                    rx_popping  = $urandom_range(0, 99) >= rx_stall_pct;
                    rx_run_left = $urandom_range(1, 8);
                end
                rx_run_left--;
                pop <= rx_popping;
            end
        end
    end

    // Compare every popped code unit with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_units.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected code unit %h last %b", o_code_unit, o_out_last);
                end
            end else begin
                head_unit = pending_units.pop_front();
                if (o_code_unit !== head_unit.unit || o_out_last !== head_unit.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("code unit wrong: expected %h last %b, got %h last %b",
                                 head_unit.unit, head_unit.last, o_code_unit, o_out_last);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no transaction happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("no transaction for %0d cycles, %0d code units outstanding",
                         quiet_cycles, pending_units.size());
                $display("unicode_escape_decoder_top: mismatch");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_in_byte      = 8'h00;
        i_in_last      = 1'b0;
        dec_mode       = ued_pkg::MODE_IDLE;
        dec_count      = 3'd0;
        dec_value      = 16'h0000;
        mismatch_count = 0;
        bytes_sent     = 0;
        quiet_cycles   = 0;
        tx_gaps_on     = 1'b1;
        tx_burst_left  = 0;
        rx_stall_pct   = 35;
        hold_request   = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_rate();
        test_escape_strings(1300);
        test_hold_off();
        test_noise();

        // Drain: wait for every predicted code unit, then watch for strays.
        while (pending_units.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("unicode_escape_decoder_top: match");
        end else begin
            $display("unicode_escape_decoder_top: mismatch");
        end
        $finish;
    end

endmodule
